### sv/elgd_pkg.sv
// ----------------------------------------------------------------------------
// ElGamal decryption package
// Shared types and constants for the decryption datapath, the sequencer and
// the modular arithmetic unit.
// ----------------------------------------------------------------------------
package elgd_pkg;

    // Width of the interface fields and default datapath width
    localparam int FIELD_W   = 32;
    localparam int DEF_WIDTH = 32;

    // Register reset values
    localparam logic [FIELD_W-1:0] RESET_MODULUS = 32'd1910759;
    localparam logic [FIELD_W-1:0] RESET_KEY     = 32'd1;

    // Configuration register indexes
    typedef enum logic {
        CFG_MODULUS = 1'b0,
        CFG_KEY     = 1'b1
    } t_cfg_idx;

    // Operation of the shared modular unit
    typedef enum logic {
        OP_RED = 1'b0,   // x mod m, one dividend bit a cycle
        OP_MUL = 1'b1    // x * y mod m, shift-add, one multiplier bit a cycle
    } t_op;

    // Command from sequencer to unit
    typedef struct packed {
        logic start;
        t_op  op;
    } t_cmd;

    // Status from unit to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_stat;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RED_B,
        S_RED_C,
        S_RED_A,
        S_POW_CHK,
        S_POW_MUL,
        S_POW_SQR,
        S_FINAL
    } t_state;

endpackage

### sv/elgamal_decrypt.sv
// ----------------------------------------------------------------------------
// ElGamal decryption
// Recovers m = B^(p-1-a) * C mod p from one ciphertext pair, with p and a
// held in configuration registers.
//
//   channel   direction  beat marked by        payload
//   command   in         start & !busy         i_cipher_b, i_cipher_c
//   result    out        o_plain_valid         o_plain_value
//   config    in         i_cfg_we              i_cfg_idx, i_cfg_wdata
//
// One pair runs three reductions, then per exponent bit a check, a square
// and, for a set bit, a multiply, and last the product with C; every
// product goes through the shared shift-add unit, and the result beat is
// registered. With a modulus below two the result beat follows start in
// the next cycle.
// Reset is synchronous and active low; it restores the register defaults.
// The result beat lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module elgamal_decrypt
    import elgd_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FIELD_W-1:0] i_cipher_b,
    input  logic [FIELD_W-1:0] i_cipher_c,
    output logic               o_plain_valid,
    output logic [FIELD_W-1:0] o_plain_value,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [FIELD_W-1:0] i_cfg_wdata
);

    logic [FIELD_W-1:0] r_modulus;
    logic [FIELD_W-1:0] r_key;

    logic [WIDTH-1:0]   w_b, w_c, w_p, w_a;
    logic [WIDTH-1:0]   w_plain;
    logic [WIDTH-1:0]   w_opx, w_opy, w_opm, w_res;
    t_cmd               w_cmd;
    t_stat              w_stat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= RESET_MODULUS;
            r_key     <= RESET_KEY;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODULUS: r_modulus <= i_cfg_wdata;
                CFG_KEY:     r_key     <= i_cfg_wdata;
                default:     r_key     <= r_key;
            endcase
        end
    end

    // Fit fields to the datapath width
    assign w_b = WIDTH'(i_cipher_b);
    assign w_c = WIDTH'(i_cipher_c);
    assign w_p = WIDTH'(r_modulus);
    assign w_a = WIDTH'(r_key);

    elgd_seq #(
        .WIDTH (WIDTH)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_b     (w_b),
        .i_c     (w_c),
        .i_p     (w_p),
        .i_a     (w_a),
        .o_valid (o_plain_valid),
        .o_plain (w_plain),
        .o_cmd   (w_cmd),
        .o_opx   (w_opx),
        .o_opy   (w_opy),
        .o_opm   (w_opm),
        .i_stat  (w_stat),
        .i_res   (w_res)
    );

    elgd_modunit #(
        .WIDTH (WIDTH)
    ) u_modunit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_opx   (w_opx),
        .i_opy   (w_opy),
        .i_opm   (w_opm),
        .o_stat  (w_stat),
        .o_res   (w_res)
    );

    assign o_plain_value = FIELD_W'(w_plain);

`ifndef SYNTHESIS
    // A result beat never coincides with an item in flight
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_plain_valid |-> !busy)
        else $error("result beat while busy");

    // The shared unit only works while the sequencer holds an item
    a_unit_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !w_stat.busy)
        else $error("modular unit active with sequencer idle");

    // An accepted item with a real modulus occupies the block next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (w_p > WIDTH'(1))) |=> busy)
        else $error("accepted item did not start");
`endif

endmodule

### sv/elgd_modunit.sv
// ----------------------------------------------------------------------------
// ElGamal modular arithmetic unit
// Shared iterative unit: restoring reduction x mod m, or shift-add modular
// product x * y mod m. One step per cycle; done pulses with the result held.
// ----------------------------------------------------------------------------
module elgd_modunit
    import elgd_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [WIDTH-1:0] i_opx,
    input  logic [WIDTH-1:0] i_opy,
    input  logic [WIDTH-1:0] i_opm,
    output t_stat            o_stat,
    output logic [WIDTH-1:0] o_res
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             r_busy;
    t_op              r_op;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_add;
    logic [WIDTH-1:0] r_y;
    logic [WIDTH-1:0] r_m;
    logic [CW-1:0]    r_cnt;

    logic             w_finish;
    logic [WIDTH-1:0] w_gap;
    logic [WIDTH-1:0] w_acc_mul;
    logic [WIDTH-1:0] w_add_dbl;
    logic [WIDTH:0]   w_trial;
    logic [WIDTH-1:0] w_acc_red;

    // Finish when the multiplier bits run out or all dividend bits are in
    assign w_finish = (r_op == OP_MUL) ? (r_y == '0) : (r_cnt == '0);

    // Modular add of addend into accumulator and modular doubling of addend
    always_comb begin
        w_gap = r_m - r_add;
        if (!r_y[0]) begin
            w_acc_mul = r_acc;
        end else if (r_acc >= w_gap) begin
            w_acc_mul = r_acc - w_gap;
        end else begin
            w_acc_mul = r_acc + r_add;
        end
        if (r_add >= w_gap) begin
            w_add_dbl = r_add - w_gap;
        end else begin
            w_add_dbl = r_add + r_add;
        end
    end

    // Restoring reduction step: shift in the next dividend bit, subtract if able
    always_comb begin
        w_trial = {r_acc, r_y[WIDTH-1]};
        if (w_trial >= {1'b0, r_m}) begin
            w_acc_red = WIDTH'(w_trial - {1'b0, r_m});
        end else begin
            w_acc_red = w_trial[WIDTH-1:0];
        end
    end

    // Control: load on start, drop busy once finished
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && w_finish) begin
            r_busy <= 1'b0;
        end
    end

    // Operands and iteration
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_cmd.op;
            r_m   <= i_opm;
            r_acc <= '0;
            r_cnt <= CW'(WIDTH);
            if (i_cmd.op == OP_MUL) begin
                r_add <= i_opx;
                r_y   <= i_opy;
            end else begin
                r_add <= '0;
                r_y   <= i_opx;
            end
        end else if (r_busy && !w_finish) begin
            if (r_op == OP_MUL) begin
                r_acc <= w_acc_mul;
                r_add <= w_add_dbl;
                r_y   <= r_y >> 1;
            end else begin
                r_acc <= w_acc_red;
                r_y   <= r_y << 1;
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && w_finish;
    assign o_res       = r_acc;

endmodule

### sv/elgd_seq.sv
// ----------------------------------------------------------------------------
// ElGamal decryption sequencer
// Reduces the ciphertext pair and key, then runs square-and-multiply and the
// final product through the shared modular unit.
// ----------------------------------------------------------------------------
module elgd_seq
    import elgd_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_c,
    input  logic [WIDTH-1:0] i_p,
    input  logic [WIDTH-1:0] i_a,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_plain,
    output t_cmd             o_cmd,
    output logic [WIDTH-1:0] o_opx,
    output logic [WIDTH-1:0] o_opy,
    output logic [WIDTH-1:0] o_opm,
    input  t_stat            i_stat,
    input  logic [WIDTH-1:0] i_res
);

    t_state           r_state, n_state;
    logic             r_valid, n_valid;
    logic [WIDTH-1:0] r_plain, n_plain;
    logic [WIDTH-1:0] r_base, n_base;   // cipher_b, then the running square
    logic [WIDTH-1:0] r_c, n_c;
    logic [WIDTH-1:0] r_e, n_e;         // remaining exponent
    logic [WIDTH-1:0] r_r, n_r;         // running power

    logic [WIDTH-1:0] w_order;

    assign w_order = i_p - 1'b1;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_plain <= n_plain;
        r_base  <= n_base;
        r_c     <= n_c;
        r_e     <= n_e;
        r_r     <= n_r;
    end

    // Next state, unit commands and datapath updates
    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_plain   = r_plain;
        n_base    = r_base;
        n_c       = r_c;
        n_e       = r_e;
        n_r       = r_r;
        o_cmd     = '{start: 1'b0, op: OP_RED};
        o_opx     = '0;
        o_opy     = '0;
        o_opm     = i_p;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_c = i_c;
                    if (i_p < WIDTH'(2)) begin
                        // No residue system: result is zero at once
                        n_valid = 1'b1;
                        n_plain = '0;
                    end else begin
                        o_cmd   = '{start: 1'b1, op: OP_RED};
                        o_opx   = i_b;
                        n_state = S_RED_B;
                    end
                end
            end
            S_RED_B: begin
                if (i_stat.done) begin
                    n_base  = i_res;
                    o_cmd   = '{start: 1'b1, op: OP_RED};
                    o_opx   = r_c;
                    n_state = S_RED_C;
                end
            end
            S_RED_C: begin
                if (i_stat.done) begin
                    n_c     = i_res;
                    o_cmd   = '{start: 1'b1, op: OP_RED};
                    o_opx   = i_a;
                    o_opm   = w_order;
                    n_state = S_RED_A;
                end
            end
            S_RED_A: begin
                if (i_stat.done) begin
                    n_e     = w_order - i_res;
                    n_r     = WIDTH'(1);
                    n_state = S_POW_CHK;
                end
            end
            S_POW_CHK: begin
                if (r_e == '0) begin
                    o_cmd   = '{start: 1'b1, op: OP_MUL};
                    o_opx   = r_r;
                    o_opy   = r_c;
                    n_state = S_FINAL;
                end else if (r_e[0]) begin
                    o_cmd   = '{start: 1'b1, op: OP_MUL};
                    o_opx   = r_r;
                    o_opy   = r_base;
                    n_state = S_POW_MUL;
                end else begin
                    o_cmd   = '{start: 1'b1, op: OP_MUL};
                    o_opx   = r_base;
                    o_opy   = r_base;
                    n_state = S_POW_SQR;
                end
            end
            S_POW_MUL: begin
                if (i_stat.done) begin
                    n_r     = i_res;
                    o_cmd   = '{start: 1'b1, op: OP_MUL};
                    o_opx   = r_base;
                    o_opy   = r_base;
                    n_state = S_POW_SQR;
                end
            end
            S_POW_SQR: begin
                if (i_stat.done) begin
                    n_base  = i_res;
                    n_e     = r_e >> 1;
                    n_state = S_POW_CHK;
                end
            end
            S_FINAL: begin
                if (i_stat.done) begin
                    n_plain = i_res;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_plain = r_plain;

endmodule
